>>> hdl/lsix_pkg.sv
// shared types and constants for the insertion sorter
package lsix_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int POS_W       = 6;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last;
    } item_beat_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sorted_value;
        logic [POS_W-1:0]              position;
        logic signed [VALUE_WIDTH-1:0] running_sum;
        logic                          end_of_run;
        logic                          overflowed;
    } result_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE_HEAD,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } state_t;

endpackage

>>> hdl/lsix_ram.sv
// value store: one write port, one registered read port
module lsix_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/load_sort_index_xor_sum.sv
// top level: insertion sorter with position-xor running sum
//
// Values of a run are kept in ascending signed order in a single-port-write
// memory. A value for an empty store is written directly; one for a full store
// is dropped and sets the overflow flag. Else the insertion loop moves each
// greater stored value up one place, one entry per cycle through the memory
// read and write ports. The run is emitted after the marked beat, one result
// at a time: read, added into the running sum, registered and held while
// result_ready is low. item_ready is low while inserting and until the last
// result of the run is taken. The store needs no clearing after reset.
module load_sort_index_xor_sum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  lsix_pkg::item_beat_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lsix_pkg::result_beat_t result
);

    localparam int VW = lsix_pkg::VALUE_WIDTH;
    localparam int AW = lsix_pkg::ADDR_W;
    localparam int CW = lsix_pkg::CNT_W;

    lsix_pkg::state_t state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          k_reg, k_next;
    logic signed [VW-1:0]   v_reg, v_next;
    logic                   last_reg, last_next;
    logic signed [VW-1:0]   sum_reg, sum_next;
    lsix_pkg::result_beat_t out_reg, out_next;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VW-1:0]          wdata;
    logic [AW-1:0]          raddr;
    logic [VW-1:0]          rdata;
    logic                   is_end;
    logic                   item_fire;
    logic [VW-1:0]          xor_term;

    lsix_ram #(
        .DEPTH(lsix_pkg::MAX_ITEMS),
        .WIDTH(VW)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign item_ready   = (state_reg == lsix_pkg::ST_IDLE);
    assign result_valid = (state_reg == lsix_pkg::ST_EMIT_WAIT);
    assign result       = out_reg;
    assign item_fire    = item_valid && item_ready;
    assign is_end       = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign xor_term     = VW'(k_reg) ^ rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsix_pkg::ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        k_reg    <= k_next;
        v_reg    <= v_next;
        last_reg <= last_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        out_next   = out_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = v_reg;
        raddr      = k_reg + AW'(1);

        unique case (state_reg)
            lsix_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    v_next    = item.value;
                    last_next = item.last;
                    if (count_reg == CW'(lsix_pkg::MAX_ITEMS))
                    begin
                        ovf_next = 1'b1;
                        if (item.last)
                        begin
                            state_next = lsix_pkg::ST_EMIT_READ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = item.value;
                        count_next = CW'(1);
                        if (item.last)
                        begin
                            state_next = lsix_pkg::ST_EMIT_READ;
                        end
                    end
                    else
                    begin
                        pos_next   = count_reg[AW-1:0];
                        raddr      = count_reg[AW-1:0] - AW'(1);
                        state_next = lsix_pkg::ST_INSERT;
                    end
                end
            end

            lsix_pkg::ST_INSERT:
            begin
                we = 1'b1;
                if ($signed(rdata) > v_reg)
                begin
                    waddr    = pos_reg;
                    wdata    = rdata;
                    pos_next = pos_reg - AW'(1);
                    raddr    = pos_reg - AW'(2);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = lsix_pkg::ST_PLACE_HEAD;
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? lsix_pkg::ST_EMIT_READ : lsix_pkg::ST_IDLE;
                end
            end

            lsix_pkg::ST_PLACE_HEAD:
            begin
                we         = 1'b1;
                waddr      = '0;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? lsix_pkg::ST_EMIT_READ : lsix_pkg::ST_IDLE;
            end

            lsix_pkg::ST_EMIT_READ:
            begin
                raddr      = '0;
                k_next     = '0;
                sum_next   = '0;
                state_next = lsix_pkg::ST_EMIT_LOAD;
            end

            lsix_pkg::ST_EMIT_LOAD:
            begin
                sum_next              = sum_reg + $signed(xor_term);
                out_next.sorted_value = rdata;
                out_next.position     = lsix_pkg::POS_W'(k_reg);
                out_next.running_sum  = sum_reg + $signed(xor_term);
                out_next.end_of_run   = is_end;
                out_next.overflowed   = ovf_reg;
                state_next            = lsix_pkg::ST_EMIT_WAIT;
            end

            lsix_pkg::ST_EMIT_WAIT:
            begin
                if (result_ready)
                begin
                    if (out_reg.end_of_run)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = lsix_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = lsix_pkg::ST_EMIT_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = lsix_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lsix_checker.sv
// port-level checks for the insertion sorter, bound to the top level
module lsix_port_checks (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input lsix_pkg::item_beat_t   item,
    input logic                   result_valid,
    input logic                   result_ready,
    input lsix_pkg::result_beat_t result
);

    // result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat dropped or changed while stalled");

    // loading and emitting never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
    else $error("item_ready high during emit");

    // end of run hands back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.end_of_run |=> item_ready)
    else $error("not ready after end of run");

    // next result follows with the next position
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.end_of_run
        |=> !result_valid ##1 (result_valid
            && result.position == $past(result.position, 2) + 6'd1))
    else $error("result position did not advance");

endmodule

bind load_sort_index_xor_sum lsix_port_checks u_lsix_checker (.*);
